// ----- rtl/core/pfd_pkg.sv -----
// shared types and constants for the periodic fractional distance block
// no dependencies; every other file refers to it by scoped names
package pfd_pkg;

   localparam int COORD_W    = 32;   // fractional coordinate, unsigned Q0.32
   localparam int LAT_W      = 32;   // lattice component, signed Q16.16
   localparam int DIST_W     = 32;   // distance, unsigned Q16.16
   localparam int IN_DATA_W  = 6 * COORD_W;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int REG_IDX_W  = 3;
   localparam int RAD_W      = 64;   // integer root radicand
   localparam int ROOT_W     = 32;   // root bits, one per stage
   localparam int REM_W      = ROOT_W + 3;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_AX_AY = 3'd0,
      REG_AZ_BX = 3'd1,
      REG_BY_BZ = 3'd2,
      REG_CX_CY = 3'd3,
      REG_CZ    = 3'd4
   } reg_idx_type;

   // a.x a.y a.z b.x b.y b.z c.x c.y c.z in elements 0 to 8
   typedef logic [8:0][LAT_W-1:0] lattice_type;

   typedef struct packed {
      logic valid;
      logic sat;
   } sqrt_tag_type;

endpackage

// ----- rtl/core/periodic_fractional_distance.sv -----
// top level: minimum-image distance of two points in a periodic cell
// depends on pfd_pkg, pfd_front, pfd_sumsq and pfd_sqrt_stage
//
//   port group  direction  handshake            payload
//   req_*       in         tvalid/tready        two points, six Q0.32 coordinates
//   rsp_*       out        tvalid/tready        distance Q16.16, saturated in tuser
//   csr_*       in         psel/penable/pready  3x3 lattice, signed Q16.16
//
// one item per cycle sustained while no result waits in the skid register
// the pipeline is 8 arithmetic stages, the 32-stage root (one bit per stage)
// and the output register
// reset clears valid bits, the output stage and the lattice registers
// a stall holds every stage; req_tready falls only while a result sits in the
// skid register, and it is a flop output with no path from rsp_tready
module periodic_fractional_distance #(
   parameter int FRAC_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z from bit 0 up
   input  logic [pfd_pkg::IN_DATA_W-1:0]      req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // distance
   output logic [pfd_pkg::DIST_W-1:0]         rsp_tdata,
   // saturated
   output logic                               rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pfd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pfd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pfd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int MAG_W   = FRAC_BITS + pfd_pkg::LAT_W;
   localparam int ROOT_W  = pfd_pkg::ROOT_W;
   localparam int HALF_W  = pfd_pkg::CSR_DATA_W / 2;

   // lattice registers
   logic [pfd_pkg::CSR_DATA_W-1:0]  ax_ay_ff, az_bx_ff, by_bz_ff, cx_cy_ff;
   logic [pfd_pkg::LAT_W-1:0]       cz_ff;
   logic                            csr_wr;
   pfd_pkg::reg_idx_type            csr_idx;
   pfd_pkg::lattice_type            lattice;

   // pipeline
   logic                            en;
   logic                            front_valid;
   logic [2:0][MAG_W-1:0]           front_mag;
   pfd_pkg::sqrt_tag_type           sq_tag  [ROOT_W+1];
   logic [pfd_pkg::RAD_W-1:0]       sq_rad  [ROOT_W+1];
   logic [pfd_pkg::REM_W-1:0]       sq_rem  [ROOT_W+1];
   logic [ROOT_W-1:0]               sq_root [ROOT_W+1];

   // output register plus skid register
   logic                            incoming;
   logic [pfd_pkg::DIST_W-1:0]      inc_dist;
   logic                            inc_sat;
   logic                            out_v_ff, out_v_in;
   logic [pfd_pkg::DIST_W-1:0]      out_dist_ff, out_dist_in;
   logic                            out_sat_ff, out_sat_in;
   logic                            skid_v_ff, skid_v_in;
   logic [pfd_pkg::DIST_W-1:0]      skid_dist_ff, skid_dist_in;
   logic                            skid_sat_ff, skid_sat_in;

   // ---------------------------------------------------------------------
   // configuration port, register i at byte address 8*i
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = pfd_pkg::reg_idx_type'(csr_paddr[pfd_pkg::CSR_ADDR_W-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ay_ff <= '0;
         az_bx_ff <= '0;
         by_bz_ff <= '0;
         cx_cy_ff <= '0;
         cz_ff    <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            pfd_pkg::REG_AX_AY: ax_ay_ff <= csr_pwdata;
            pfd_pkg::REG_AZ_BX: az_bx_ff <= csr_pwdata;
            pfd_pkg::REG_BY_BZ: by_bz_ff <= csr_pwdata;
            pfd_pkg::REG_CX_CY: cx_cy_ff <= csr_pwdata;
            pfd_pkg::REG_CZ:    cz_ff    <= csr_pwdata[pfd_pkg::LAT_W-1:0];
            default: ;   // addresses past the list are ignored
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         pfd_pkg::REG_AX_AY: csr_prdata = ax_ay_ff;
         pfd_pkg::REG_AZ_BX: csr_prdata = az_bx_ff;
         pfd_pkg::REG_BY_BZ: csr_prdata = by_bz_ff;
         pfd_pkg::REG_CX_CY: csr_prdata = cx_cy_ff;
         pfd_pkg::REG_CZ:    csr_prdata = pfd_pkg::CSR_DATA_W'(cz_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // the user must change the lattice only while idle (not enforced), so stages read it directly
   assign lattice[0] = ax_ay_ff[HALF_W-1:0];
   assign lattice[1] = ax_ay_ff[pfd_pkg::CSR_DATA_W-1:HALF_W];
   assign lattice[2] = az_bx_ff[HALF_W-1:0];
   assign lattice[3] = az_bx_ff[pfd_pkg::CSR_DATA_W-1:HALF_W];
   assign lattice[4] = by_bz_ff[HALF_W-1:0];
   assign lattice[5] = by_bz_ff[pfd_pkg::CSR_DATA_W-1:HALF_W];
   assign lattice[6] = cx_cy_ff[HALF_W-1:0];
   assign lattice[7] = cx_cy_ff[pfd_pkg::CSR_DATA_W-1:HALF_W];
   assign lattice[8] = cz_ff;

   // ---------------------------------------------------------------------
   // arithmetic pipeline, all stages advance together on en
   // ---------------------------------------------------------------------
   assign en         = ~skid_v_ff;
   assign req_tready = en;

   pfd_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_first  (req_tdata[3*pfd_pkg::COORD_W-1:0]),
      .in_second (req_tdata[pfd_pkg::IN_DATA_W-1:3*pfd_pkg::COORD_W]),
      .lattice   (lattice),
      .out_valid (front_valid),
      .out_mag   (front_mag)
   );

   pfd_sumsq #(
      .FRAC_BITS (FRAC_BITS)
   ) u_sumsq (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (front_valid),
      .in_mag   (front_mag),
      .out_tag  (sq_tag[0]),
      .out_rad  (sq_rad[0])
   );

   // root of the upper 64 bits of the sum of squares gives the Q16.16 floor
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar s = 0; s < ROOT_W; s++) begin : g_root
      pfd_sqrt_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_tag   (sq_tag[s]),
         .in_rad   (sq_rad[s]),
         .in_rem   (sq_rem[s]),
         .in_root  (sq_root[s]),
         .out_tag  (sq_tag[s+1]),
         .out_rad  (sq_rad[s+1]),
         .out_rem  (sq_rem[s+1]),
         .out_root (sq_root[s+1])
      );
   end

   // ---------------------------------------------------------------------
   // output register and skid register
   // ---------------------------------------------------------------------
   assign incoming = sq_tag[ROOT_W].valid & en;
   assign inc_sat  = sq_tag[ROOT_W].sat;
   assign inc_dist = inc_sat ? '1 : sq_root[ROOT_W];

   always_comb begin
      out_v_in     = out_v_ff;
      out_dist_in  = out_dist_ff;
      out_sat_in   = out_sat_ff;
      skid_v_in    = skid_v_ff;
      skid_dist_in = skid_dist_ff;
      skid_sat_in  = skid_sat_ff;
      if (skid_v_ff) begin
         // pipeline is held; drain the skid into the output register
         if (rsp_tready) begin
            out_dist_in = skid_dist_ff;
            out_sat_in  = skid_sat_ff;
            skid_v_in   = 1'b0;
         end
      end else if (incoming) begin
         if (!out_v_ff || rsp_tready) begin
            out_v_in    = 1'b1;
            out_dist_in = inc_dist;
            out_sat_in  = inc_sat;
         end else begin
            skid_v_in    = 1'b1;
            skid_dist_in = inc_dist;
            skid_sat_in  = inc_sat;
         end
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_dist_ff  <= out_dist_in;
      out_sat_ff   <= out_sat_in;
      skid_dist_ff <= skid_dist_in;
      skid_sat_ff  <= skid_sat_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_dist_ff;
   assign rsp_tuser  = out_sat_ff;

endmodule

// ----- rtl/core/pfd_front.sv -----
// front half: per-axis fold, lattice products, component sums, magnitude
// four register stages; uses pfd_pkg
module pfd_front #(
   parameter int FRAC_BITS = 32
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             en,
   input  logic                                             in_valid,
   input  logic [2:0][pfd_pkg::COORD_W-1:0]                 in_first,
   input  logic [2:0][pfd_pkg::COORD_W-1:0]                 in_second,
   input  pfd_pkg::lattice_type                             lattice,
   output logic                                             out_valid,
   output logic [2:0][FRAC_BITS+pfd_pkg::LAT_W-1:0]         out_mag
);

   localparam int MAG_W  = FRAC_BITS + pfd_pkg::LAT_W;
   localparam int PROD_W = MAG_W;
   localparam int FULL_W = MAG_W + 1;
   localparam int SUM_W  = MAG_W + 1;

   logic [3:0]                        valid_ff;
   logic [pfd_pkg::COORD_W-1:0]       diff     [3];
   logic [pfd_pkg::COORD_W-1:0]       fold32   [3];
   logic [2:0][FRAC_BITS-1:0]         fold_in, fold_ff;
   logic signed [FULL_W-1:0]          prod_full [3][3];
   logic signed [PROD_W-1:0]          prod_in  [3][3];
   logic signed [PROD_W-1:0]          prod_ff  [3][3];
   logic signed [SUM_W-1:0]           sum_in   [3];
   logic signed [SUM_W-1:0]           sum_ff   [3];
   logic signed [SUM_W-1:0]           sum_neg  [3];
   logic [2:0][MAG_W-1:0]             mag_in, mag_ff;

   // fold: min(t, 1 - t) of the wrapped difference, then keep the top bits
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k]    = in_first[k] - in_second[k];
         fold32[k]  = diff[k][pfd_pkg::COORD_W-1] ? (~diff[k] + pfd_pkg::COORD_W'(1))
                                                  : diff[k];
         fold_in[k] = fold32[k][pfd_pkg::COORD_W-1 -: FRAC_BITS];
      end
   end

   // component i gets f_j times row j, element i
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_full[i][j] = FULL_W'($signed({1'b0, fold_ff[j]}))
                            * FULL_W'($signed(lattice[3*j+i]));
            prod_in[i][j]   = prod_full[i][j][PROD_W-1:0];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_in[i]  = SUM_W'(prod_ff[i][0]) + SUM_W'(prod_ff[i][1]) + SUM_W'(prod_ff[i][2]);
         sum_neg[i] = -sum_ff[i];
         mag_in[i]  = sum_ff[i][SUM_W-1] ? sum_neg[i][MAG_W-1:0] : sum_ff[i][MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fold_ff <= fold_in;
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         mag_ff  <= mag_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_mag   = mag_ff;

endmodule

// ----- rtl/core/pfd_sumsq.sv -----
// sum of squares of the three magnitudes, range check, radicand select
// four register stages, squares split into 32-bit partial products; uses pfd_pkg
module pfd_sumsq #(
   parameter int FRAC_BITS = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        en,
   input  logic                                        in_valid,
   input  logic [2:0][FRAC_BITS+pfd_pkg::LAT_W-1:0]    in_mag,
   output pfd_pkg::sqrt_tag_type                       out_tag,
   output logic [pfd_pkg::RAD_W-1:0]                   out_rad
);

   localparam int LO_W  = 32;
   localparam int HI_W  = FRAC_BITS;
   localparam int HH_W  = 2 * HI_W;
   localparam int HL_W  = HI_W + LO_W;
   localparam int LL_W  = 2 * LO_W;
   localparam int SQ_W  = HH_W + LL_W;
   localparam int PR_W  = SQ_W + 1;
   localparam int TOT_W = SQ_W + 2;

   logic [3:0]                 valid_ff;
   logic [HI_W-1:0]            mh [3];
   logic [LO_W-1:0]            ml [3];
   logic [HH_W-1:0]            hh_in [3], hh_ff [3];
   logic [HL_W-1:0]            hl_in [3], hl_ff [3];
   logic [LL_W-1:0]            ll_in [3], ll_ff [3];
   logic [SQ_W-1:0]            sq_in [3], sq_ff [3];
   logic [PR_W-1:0]            pair_in, pair_ff;
   logic [SQ_W-1:0]            third_ff;
   logic [TOT_W-1:0]           tot;
   logic                       sat_in, sat_ff;
   logic [pfd_pkg::RAD_W-1:0]  rad_in, rad_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mh[i]    = in_mag[i][HL_W-1:LO_W];
         ml[i]    = in_mag[i][LO_W-1:0];
         hh_in[i] = HH_W'(mh[i]) * HH_W'(mh[i]);
         hl_in[i] = HL_W'(mh[i]) * HL_W'(ml[i]);
         ll_in[i] = LL_W'(ml[i]) * LL_W'(ml[i]);
         // cross term appears twice, hence the shift by one more
         sq_in[i] = {hh_ff[i], ll_ff[i]} + (SQ_W'(hl_ff[i]) << (LO_W + 1));
      end
   end

   assign pair_in = PR_W'(sq_ff[0]) + PR_W'(sq_ff[1]);

   // length out of range when the sum of squares reaches 2^(64 + 2*frac)
   always_comb begin
      tot    = TOT_W'(pair_ff) + TOT_W'(third_ff);
      sat_in = |tot[TOT_W-1:SQ_W];
      rad_in = tot[SQ_W-1:2*FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff    <= hh_in;
         hl_ff    <= hl_in;
         ll_ff    <= ll_in;
         sq_ff    <= sq_in;
         pair_ff  <= pair_in;
         third_ff <= sq_ff[2];
         sat_ff   <= sat_in;
         rad_ff   <= rad_in;
      end
   end

   assign out_tag.valid = valid_ff[3];
   assign out_tag.sat   = sat_ff;
   assign out_rad       = rad_ff;

endmodule

// ----- rtl/core/pfd_sqrt_stage.sv -----
// one stage of the digit-by-digit integer square root: one root bit per stage
// uses pfd_pkg for widths and the tag struct
module pfd_sqrt_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  pfd_pkg::sqrt_tag_type       in_tag,
   input  logic [pfd_pkg::RAD_W-1:0]   in_rad,
   input  logic [pfd_pkg::REM_W-1:0]   in_rem,
   input  logic [pfd_pkg::ROOT_W-1:0]  in_root,
   output pfd_pkg::sqrt_tag_type       out_tag,
   output logic [pfd_pkg::RAD_W-1:0]   out_rad,
   output logic [pfd_pkg::REM_W-1:0]   out_rem,
   output logic [pfd_pkg::ROOT_W-1:0]  out_root
);

   localparam int REM_W  = pfd_pkg::REM_W;
   localparam int ROOT_W = pfd_pkg::ROOT_W;
   localparam int RAD_W  = pfd_pkg::RAD_W;

   logic                  valid_ff;
   logic                  sat_ff;
   logic [REM_W-1:0]      rem_sh, trial;
   logic [REM_W-1:0]      rem_in, rem_ff;
   logic [ROOT_W-1:0]     root_in, root_ff;
   logic [RAD_W-1:0]      rad_in, rad_ff;

   always_comb begin
      // bring down the next two radicand bits
      rem_sh = {in_rem[REM_W-3:0], in_rad[RAD_W-1 -: 2]};
      trial  = REM_W'({in_root, 2'b01});
      rad_in = {in_rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {in_root[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         root_in = {in_root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff  <= in_tag.sat;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
      end
   end

   assign out_tag.valid = valid_ff;
   assign out_tag.sat   = sat_ff;
   assign out_rad       = rad_ff;
   assign out_rem       = rem_ff;
   assign out_root      = root_ff;

endmodule

// ----- rtl/core/pfd_checker.sv -----
// port-level checks for periodic_fractional_distance, attached by bind
// uses pfd_pkg for the result width
module pfd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [pfd_pkg::DIST_W-1:0]    rsp_tdata,
   input logic                          rsp_tuser
);

   // output stage is empty and input open right after a reset cycle
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("output not empty after reset");

   // a clipped result always carries the full-scale code
   a_sat_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '1)
      else $error("saturated item without full-scale distance");

   // input backpressure only follows a result that was left waiting
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> $past(rsp_tvalid && !rsp_tready))
      else $error("input stalled without output backpressure");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn before it was taken");

endmodule

bind periodic_fractional_distance pfd_checker u_pfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
